/* sv/phsc_pkg.sv */
// Shared types, constants and helper functions for the pixel hue shift block.
// No dependencies; used by every other file of the block.
package phsc_pkg;

	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_W       = 9;
	localparam int unsigned DVD_W       = 14;
	localparam int unsigned QUO_W       = 6;

	localparam logic [2:0] REG_BLUE_RED   = 3'd0;
	localparam logic [2:0] REG_BLUE_GREEN = 3'd1;
	localparam logic [2:0] REG_BLUE_BLUE  = 3'd2;
	localparam logic [2:0] REG_PINK_RED   = 3'd3;
	localparam logic [2:0] REG_PINK_GREEN = 3'd4;
	localparam logic [2:0] REG_PINK_BLUE  = 3'd5;

	localparam logic [7:0] BASE_RED   = 8'd0;
	localparam logic [7:0] BASE_GREEN = 8'd85;
	localparam logic [7:0] BASE_BLUE  = 8'd171;
	localparam logic [7:0] SECTOR_W   = 8'd43;

	// front half of an RGB to HSV conversion, up to the hue division
	typedef struct packed {
		logic [7:0]       mx;
		logic [7:0]       d;
		logic [7:0]       base;
		logic             neg;
		logic [DVD_W-1:0] dvd;
	} hfr_t;

	typedef struct packed {
		logic [2:0] sec;
		logic [7:0] rem6;
	} secrem_t;

	function automatic hfr_t hsv_front(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		hfr_t       f;
		logic [7:0] mn;
		logic [7:0] mag;
		f.mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn   = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		f.d  = f.mx - mn;
		if (f.mx == r) begin
			f.base = BASE_RED;
			f.neg  = g < b;
			mag    = f.neg ? (b - g) : (g - b);
		end else if (f.mx == g) begin
			f.base = BASE_GREEN;
			f.neg  = b < r;
			mag    = f.neg ? (r - b) : (b - r);
		end else begin
			f.base = BASE_BLUE;
			f.neg  = r < g;
			mag    = f.neg ? (g - r) : (r - g);
		end
		// times 43 as shifts and adds
		f.dvd = ({6'd0, mag} << 5) + ({6'd0, mag} << 3) + ({6'd0, mag} << 1) + {6'd0, mag};
		return f;
	endfunction

	// hue sector and six times the position inside it
	function automatic secrem_t sec_rem(input logic [7:0] h);
		secrem_t    o;
		logic [7:0] lo;
		if (h >= 8'd215) begin
			o.sec = 3'd5;
			lo    = 8'd215;
		end else if (h >= 8'd172) begin
			o.sec = 3'd4;
			lo    = 8'd172;
		end else if (h >= 8'd129) begin
			o.sec = 3'd3;
			lo    = 8'd129;
		end else if (h >= 8'd86) begin
			o.sec = 3'd2;
			lo    = 8'd86;
		end else if (h >= SECTOR_W) begin
			o.sec = 3'd1;
			lo    = SECTOR_W;
		end else begin
			o.sec = 3'd0;
			lo    = 8'd0;
		end
		o.rem6 = ((h - lo) << 2) + ((h - lo) << 1);
		return o;
	endfunction

endpackage

/* sv/phsc_div.sv */
// Pipelined restoring divider for the hue term, two quotient bits per stage.
// Depends on phsc_pkg for widths.
module phsc_div #(
	parameter int unsigned SIDE_W = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ce,
	input  logic                           in_valid,
	input  logic [phsc_pkg::DVD_W-1:0]     dividend,
	input  logic [7:0]                     divisor,
	input  logic [SIDE_W-1:0]              side_in,
	output logic                           out_valid,
	output logic [phsc_pkg::QUO_W-1:0]     quot,
	output logic [SIDE_W-1:0]              side_out
);

	localparam int unsigned DW = phsc_pkg::DVD_W;
	localparam int unsigned QW = phsc_pkg::QUO_W;

	logic          vld_s1, vld_s2, vld_s3;
	logic [DW-1:0] rem_s1, rem_s2;
	logic [QW-1:0] quo_s1, quo_s2, quo_s3;
	logic [7:0]    dvs_s1, dvs_s2;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;

	logic [DW-1:0] rem_a, rem_b, rem_c, rem_d, rem_e;
	logic [1:0]    qb_a, qb_b, qb_c;
	logic [DW:0]   step_last;

	function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
			input logic [7:0] dvs, input int unsigned sh);
		logic [DW-1:0] trial;
		trial = {{(DW-8){1'b0}}, dvs} << sh;
		if (rem >= trial) return {1'b1, rem - trial};
		else return {1'b0, rem};
	endfunction

	always_comb begin
		{qb_a[1], rem_a} = div_step(dividend, divisor, 5);
		{qb_a[0], rem_b} = div_step(rem_a, divisor, 4);
		{qb_b[1], rem_c} = div_step(rem_s1, dvs_s1, 3);
		{qb_b[0], rem_d} = div_step(rem_c, dvs_s1, 2);
		{qb_c[1], rem_e} = div_step(rem_s2, dvs_s2, 1);
		step_last        = div_step(rem_e, dvs_s2, 0);
		qb_c[0]          = step_last[DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s1  <= rem_b;
			quo_s1  <= {qb_a, {(QW-2){1'b0}}};
			dvs_s1  <= divisor;
			side_s1 <= side_in;
			rem_s2  <= rem_d;
			quo_s2  <= {quo_s1[QW-1:QW-2], qb_b, 2'b00};
			dvs_s2  <= dvs_s1;
			side_s2 <= side_s1;
			quo_s3  <= {quo_s2[QW-1:2], qb_c};
			side_s3 <= side_s2;
		end
	end

	assign out_valid = vld_s3;
	assign quot      = quo_s3;
	assign side_out  = side_s3;

endmodule

/* sv/phsc_hsv2rgb.sv */
// Three-stage HSV to RGB converter: sector lookup and saturation products,
// value products, channel select. Depends on phsc_pkg.
module phsc_hsv2rgb (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ce,
	input  logic       in_valid,
	input  logic [7:0] hue,
	input  logic [7:0] sat,
	input  logic [7:0] val,
	input  logic       corr_in,
	output logic       out_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       corr_out
);

	phsc_pkg::secrem_t sr;

	logic        vld_s1, vld_s2, vld_s3;
	logic [2:0]  sec_s1, sec_s2;
	logic [7:0]  sat_s1, val_s1, val_s2;
	logic [15:0] srem_s1, strem_s1;
	logic        corr_s1, corr_s2, corr_s3;
	logic        sz_s1, sz_s2;
	logic [7:0]  p_s2, q_s2, t_s2;
	logic [7:0]  r_s3, g_s3, b_s3;

	logic [15:0] p_full, q_full, t_full;
	logic [7:0]  r_c, g_c, b_c;

	assign sr = phsc_pkg::sec_rem(hue);

	always_comb begin
		p_full = {8'd0, val_s1} * {8'd0, 8'd255 - sat_s1};
		q_full = {8'd0, val_s1} * {8'd0, 8'd255 - srem_s1[15:8]};
		t_full = {8'd0, val_s1} * {8'd0, 8'd255 - strem_s1[15:8]};
	end

	always_comb begin
		if (sz_s2) begin
			r_c = val_s2;
			g_c = val_s2;
			b_c = val_s2;
		end else begin
			unique case (sec_s2)
				3'd0: begin r_c = val_s2; g_c = t_s2;   b_c = p_s2;   end
				3'd1: begin r_c = q_s2;   g_c = val_s2; b_c = p_s2;   end
				3'd2: begin r_c = p_s2;   g_c = val_s2; b_c = t_s2;   end
				3'd3: begin r_c = p_s2;   g_c = q_s2;   b_c = val_s2; end
				3'd4: begin r_c = t_s2;   g_c = p_s2;   b_c = val_s2; end
				default: begin r_c = val_s2; g_c = p_s2; b_c = q_s2; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sec_s1   <= sr.sec;
			sat_s1   <= sat;
			val_s1   <= val;
			sz_s1    <= sat == 8'd0;
			srem_s1  <= {8'd0, sat} * {8'd0, sr.rem6};
			strem_s1 <= {8'd0, sat} * {8'd0, 8'd255 - sr.rem6};
			corr_s1  <= corr_in;
			sec_s2   <= sec_s1;
			val_s2   <= val_s1;
			sz_s2    <= sz_s1;
			p_s2     <= p_full[15:8];
			q_s2     <= q_full[15:8];
			t_s2     <= t_full[15:8];
			corr_s2  <= corr_s1;
			r_s3     <= r_c;
			g_s3     <= g_c;
			b_s3     <= b_c;
			corr_s3  <= corr_s2;
		end
	end

	assign out_valid = vld_s3;
	assign red       = r_s3;
	assign green     = g_s3;
	assign blue      = b_s3;
	assign corr_out  = corr_s3;

endmodule

/* sv/pixel_hue_shift_correct.sv */
// Top level of the pixel hue shift and band correction pipeline.
// Depends on phsc_pkg, phsc_div and phsc_hsv2rgb.
//
// Usage:
//   Pixels enter on the s_axis channel and leave on the m_axis channel, one
//   result item for every input item, in order. The six signed band offsets
//   are written through cfg_we / cfg_index / cfg_data while the stream is
//   idle; an index above five is ignored.
//   From acceptance to m_axis_tvalid an item passes through one stage for the
//   max/min front end, three for the hue divider, one for hue shift and
//   value boost, three for HSV to RGB, one for the second front end, three
//   for the second hue divider and one for the band offsets and clamp.
//   One item per cycle unless stalled; the divider stages are fully pipelined.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline freezes and s_axis_tready drops; nothing is lost or
//   repeated. Reset empties the pipeline and clears all offsets to zero.
module pixel_hue_shift_correct (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// in_red, in_green, in_blue, hue_shift, value_boost, apply_correction
	input  logic [phsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// out_red, out_green, out_blue
	output logic [phsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [phsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [phsc_pkg::CFG_W-1:0]           cfg_data
);

	localparam int unsigned S1_SIDE_W = 8 + 1 + 1 + 8 + 8 + 8 + 1;
	localparam int unsigned S3_SIDE_W = 8 + 1 + 1 + 8 + 8 + 8 + 1;

	logic adv;

	logic [phsc_pkg::CFG_W-1:0] off_q [6];

	phsc_pkg::hfr_t f1, f3;

	logic                        vld_s1;
	logic [phsc_pkg::DVD_W-1:0]  dvd_s1;
	logic [7:0]                  d_s1;
	logic [S1_SIDE_W-1:0]        side_s1;

	logic                        d1_valid;
	logic [phsc_pkg::QUO_W-1:0]  d1_quot;
	logic [S1_SIDE_W-1:0]        d1_side;

	logic [7:0] d1_base, d1_mx, d1_shift, d1_boost;
	logic       d1_neg, d1_dz, d1_corr;
	logic [7:0] hue1, hue_shifted;
	logic [8:0] hsum, vsum;

	logic       vld_s2, corr_s2;
	logic [7:0] h_s2, s_s2, v_s2;

	logic       c_valid, c_corr;
	logic [7:0] c_red, c_green, c_blue;

	logic                        vld_s3;
	logic [phsc_pkg::DVD_W-1:0]  dvd_s3;
	logic [7:0]                  d_s3;
	logic [S3_SIDE_W-1:0]        side_s3;

	logic                        d2_valid;
	logic [phsc_pkg::QUO_W-1:0]  d2_quot;
	logic [S3_SIDE_W-1:0]        d2_side;

	logic [7:0] d2_base, d2_r, d2_g, d2_b, hue2;
	logic       d2_neg, d2_dz, d2_corr;
	logic       in_blue_band, in_pink_band;
	logic [7:0] r_o, g_o, b_o;

	logic                                 m_valid_q;
	logic [phsc_pkg::OUT_TDATA_W-1:0]     m_data_q;
	logic                                 band_q;

	function automatic logic [7:0] adjust(input logic [7:0] c,
			input logic [phsc_pkg::CFG_W-1:0] off);
		logic signed [9:0] x;
		x = $signed({2'b00, c}) + $signed({off[8], off});
		if (x < 10'sd0) return 8'd0;
		else if (x > 10'sd254) return 8'd254;
		else return x[7:0];
	endfunction

	assign adv           = !m_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) off_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				phsc_pkg::REG_BLUE_RED:   off_q[0] <= cfg_data;
				phsc_pkg::REG_BLUE_GREEN: off_q[1] <= cfg_data;
				phsc_pkg::REG_BLUE_BLUE:  off_q[2] <= cfg_data;
				phsc_pkg::REG_PINK_RED:   off_q[3] <= cfg_data;
				phsc_pkg::REG_PINK_GREEN: off_q[4] <= cfg_data;
				phsc_pkg::REG_PINK_BLUE:  off_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: max, min and the hue dividend of the input pixel
	assign f1 = phsc_pkg::hsv_front(s_axis_tdata[7:0], s_axis_tdata[15:8],
		s_axis_tdata[23:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s1  <= f1.dvd;
			d_s1    <= f1.d;
			side_s1 <= {f1.base, f1.neg, f1.d == 8'd0, f1.mx, s_axis_tdata[31:24],
				s_axis_tdata[39:32], s_axis_tdata[40]};
		end
	end

	phsc_div #(.SIDE_W(S1_SIDE_W)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (adv),
		.in_valid (vld_s1),
		.dividend (dvd_s1),
		.divisor  (d_s1),
		.side_in  (side_s1),
		.out_valid(d1_valid),
		.quot     (d1_quot),
		.side_out (d1_side)
	);

	// hue shift with the 255 wrap, saturation and value boost
	always_comb begin
		{d1_base, d1_neg, d1_dz, d1_mx, d1_shift, d1_boost, d1_corr} = d1_side;
		if (d1_dz) hue1 = 8'd0;
		else if (d1_neg) hue1 = d1_base - {2'b00, d1_quot};
		else hue1 = d1_base + {2'b00, d1_quot};
		hsum        = {1'b0, hue1} + {1'b0, d1_shift};
		hue_shifted = hsum[8] ? hsum[7:0] + 8'd1 : hsum[7:0];
		vsum        = {1'b0, d1_mx} + {1'b0, d1_boost};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= d1_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s2    <= hue_shifted;
			s_s2    <= d1_dz ? 8'd254 : 8'd255;
			v_s2    <= vsum[8] ? 8'd255 : vsum[7:0];
			corr_s2 <= d1_corr;
		end
	end

	phsc_hsv2rgb u_hsv2rgb (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (adv),
		.in_valid (vld_s2),
		.hue      (h_s2),
		.sat      (s_s2),
		.val      (v_s2),
		.corr_in  (corr_s2),
		.out_valid(c_valid),
		.red      (c_red),
		.green    (c_green),
		.blue     (c_blue),
		.corr_out (c_corr)
	);

	// second front end, for the band test
	assign f3 = phsc_pkg::hsv_front(c_red, c_green, c_blue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= c_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s3  <= f3.dvd;
			d_s3    <= f3.d;
			side_s3 <= {f3.base, f3.neg, f3.d == 8'd0, c_red, c_green, c_blue, c_corr};
		end
	end

	phsc_div #(.SIDE_W(S3_SIDE_W)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (adv),
		.in_valid (vld_s3),
		.dividend (dvd_s3),
		.divisor  (d_s3),
		.side_in  (side_s3),
		.out_valid(d2_valid),
		.quot     (d2_quot),
		.side_out (d2_side)
	);

	always_comb begin
		{d2_base, d2_neg, d2_dz, d2_r, d2_g, d2_b, d2_corr} = d2_side;
		if (d2_dz) hue2 = 8'd0;
		else if (d2_neg) hue2 = d2_base - {2'b00, d2_quot};
		else hue2 = d2_base + {2'b00, d2_quot};
		in_blue_band = d2_corr && hue2 > 8'd100 && hue2 < 8'd150;
		in_pink_band = d2_corr && hue2 >= 8'd150 && hue2 != 8'd255;
		priority if (in_blue_band) begin
			r_o = adjust(d2_r, off_q[0]);
			g_o = adjust(d2_g, off_q[1]);
			b_o = adjust(d2_b, off_q[2]);
		end else if (in_pink_band) begin
			r_o = adjust(d2_r, off_q[3]);
			g_o = adjust(d2_g, off_q[4]);
			b_o = adjust(d2_b, off_q[5]);
		end else begin
			r_o = d2_r;
			g_o = d2_g;
			b_o = d2_b;
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (adv) m_valid_q <= d2_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {b_o, g_o, r_o};
			band_q   <= in_blue_band || in_pink_band;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({vld_s1, vld_s2, vld_s3, d1_valid, c_valid, d2_valid}))
		else $error("pipeline valid bits moved during a stall");

	a_sat_boosted: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (s_s2 == 8'd254 || s_s2 == 8'd255))
		else $error("saturation after boost is not 254 or 255");

	a_band_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && band_q) |-> (m_data_q[7:0] != 8'd255 && m_data_q[15:8] != 8'd255
			&& m_data_q[23:16] != 8'd255))
		else $error("corrected channel exceeds 254");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking bench for pixel_hue_shift_correct: pixel hue shift, value boost and band offsets.
// Depends on phsc_pkg and the block's RTL; carries its own bit-exact pixel predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// red sits in the low byte, as on m_axis_tdata
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	// in_red, in_green, in_blue, hue_shift, value_boost, apply_correction, zero pad
	logic [phsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// out_red, out_green, out_blue
	logic [phsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             cfg_we = 1'b0;
	logic [phsc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [phsc_pkg::CFG_W-1:0]       cfg_data = '0;

	logic [phsc_pkg::CFG_W-1:0] band_offset [6];
	pix_t             pixel_q [$];
	int               n_errors = 0;
	int               n_items = 0;
	int               n_results = 0;
	int               n_corrected = 0;
	longint           cycle = 0;
	bit               rx_stall_on = 1'b1;

	localparam longint CYCLE_LIMIT = 400000;

	pixel_hue_shift_correct DUT (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic rgb_to_hsv(input int r, input int g, input int b,
			output int h, output int s, output int v);
		int mx, mn, d, base, diff, mag, term;
		mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		d = mx - mn;
		v = mx;
		h = 0;
		s = 0;
		if (mx == 0) return;
		s = (255 * d) / mx;
		if (s == 0) return;
		if (mx == r) begin
			base = 0;
			diff = g - b;
		end else if (mx == g) begin
			base = 85;
			diff = b - r;
		end else begin
			base = 171;
			diff = r - g;
		end
		mag = (diff < 0) ? -diff : diff;
		term = (43 * mag) / d;
		if (diff < 0) term = -term;
		h = (base + term + 256) & 255;
	endtask

	function automatic int clamp_offset(input int c, input logic [phsc_pkg::CFG_W-1:0] off);
		int x;
		x = c + int'($signed(off));
		if (x < 0) return 0;
		if (x > 254) return 254;
		return x;
	endfunction

	task automatic predict_pixel(input logic [phsc_pkg::IN_TDATA_W-1:0] item, output pix_t px);
		int r, g, b, h, s, v, sec, rem, p, q, t, base;
		rgb_to_hsv(int'(item[7:0]), int'(item[15:8]), int'(item[23:16]), h, s, v);
		h = h + int'(item[31:24]);
		if (h > 255) h = h - 255;
		s = (s + 254 > 255) ? 255 : s + 254;
		v = (v + int'(item[39:32]) > 255) ? 255 : v + int'(item[39:32]);
		if (s == 0) begin
			r = v; g = v; b = v;
		end else begin
			sec = h / 43;
			rem = (h - sec * 43) * 6;
			p = ((v * (255 - s)) >> 8) & 255;
			q = ((v * (255 - ((s * rem) >> 8))) >> 8) & 255;
			t = ((v * (255 - ((s * (255 - rem)) >> 8))) >> 8) & 255;
			case (sec)
				0: begin r = v; g = t; b = p; end
				1: begin r = q; g = v; b = p; end
				2: begin r = p; g = v; b = t; end
				3: begin r = p; g = q; b = v; end
				4: begin r = t; g = p; b = v; end
				default: begin r = v; g = p; b = q; end
			endcase
		end
		if (item[40]) begin
			base = -1;
			rgb_to_hsv(r, g, b, h, s, v);
			if (h > 100 && h < 150) base = phsc_pkg::REG_BLUE_RED;
			else if (h >= 150 && h < 255) base = phsc_pkg::REG_PINK_RED;
			if (base >= 0) begin
				n_corrected++;
				r = clamp_offset(r, band_offset[base]);
				g = clamp_offset(g, band_offset[base + 1]);
				b = clamp_offset(b, band_offset[base + 2]);
			end
		end
		px = '{red: r[7:0], green: g[7:0], blue: b[7:0]};
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle);
	endtask

	// send one pixel; a burst-style random gap goes ahead of each burst
	int burst_left = 0;
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] shift, input logic [7:0] boost, input logic corr);
		logic [phsc_pkg::IN_TDATA_W-1:0] item;
		pix_t px;
		int gap;
		item = {7'd0, corr, boost, shift, b, g, r};
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= item;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_pixel(item, px);
		pixel_q.push_back(px);
		n_items++;
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (cycle % 300 == 0) rx_stall_on <= ~rx_stall_on;
		m_axis_tready <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	always @(posedge clk) begin
		pix_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			n_results++;
			if (pixel_q.size() == 0) begin
				report_mismatch("unexpected item, count", n_results, n_items);
			end else begin
				want = pixel_q.pop_front();
				if (got.red !== want.red) report_mismatch("out_red", got.red, want.red);
				if (got.green !== want.green)
					report_mismatch("out_green", got.green, want.green);
				if (got.blue !== want.blue) report_mismatch("out_blue", got.blue, want.blue);
			end
		end
	end

	task automatic drain();
		int guard;
		end_burst();
		guard = 0;
		while (pixel_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_offset(input logic [phsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [phsc_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx <= phsc_pkg::REG_PINK_BLUE) band_offset[idx] = val;
	endtask

	task automatic set_all_offsets(input logic [phsc_pkg::CFG_W-1:0] v0,
			input logic [phsc_pkg::CFG_W-1:0] v1, input logic [phsc_pkg::CFG_W-1:0] v2,
			input logic [phsc_pkg::CFG_W-1:0] v3, input logic [phsc_pkg::CFG_W-1:0] v4,
			input logic [phsc_pkg::CFG_W-1:0] v5);
		write_offset(phsc_pkg::REG_BLUE_RED, v0);
		write_offset(phsc_pkg::REG_BLUE_GREEN, v1);
		write_offset(phsc_pkg::REG_BLUE_BLUE, v2);
		write_offset(phsc_pkg::REG_PINK_RED, v3);
		write_offset(phsc_pkg::REG_PINK_GREEN, v4);
		write_offset(phsc_pkg::REG_PINK_BLUE, v5);
	endtask

	task automatic test_directed_pixels();
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);         // black
		send_pixel(8'd128, 8'd128, 8'd128, 8'd7, 8'd0, 1'b1);   // grey
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd10, 8'd200, 8'd0, 8'd0, 1'b1);    // red max, blue above green
		send_pixel(8'd200, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd200, 8'd100, 1'b1);   // hue wraps past 255
		send_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd130, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd180, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd254, 8'd255, 1'b1);
		send_pixel(8'd1, 8'd0, 8'd0, 8'd120, 8'd0, 1'b1);
		send_pixel(8'd0, 8'd1, 8'd2, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd60, 8'd90, 8'd240, 8'd0, 8'd40, 1'b1);
		send_pixel(8'd240, 8'd90, 8'd200, 8'd0, 8'd0, 1'b1);
		drain();
	endtask

	task automatic test_random_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
			else
				// saturated colors land in the bands more often
				send_pixel($urandom_range(0, 3) == 0 ? 8'd255 : 8'($urandom),
					$urandom_range(0, 2) == 0 ? 8'd0 : 8'($urandom), 8'($urandom),
					8'($urandom), $urandom_range(0, 1) ? 8'd0 : 8'($urandom),
					$urandom_range(0, 4) != 0);
		end
		drain();
	endtask

	initial begin
		foreach (band_offset[i]) band_offset[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_pixels();
		set_all_offsets(9'h0ff, 9'h101, 9'h100, 9'h000, 9'h1ff, 9'h001);
		write_offset(3'd6, 9'h0aa);   // ignored
		write_offset(3'd7, 9'h155);   // ignored
		test_directed_pixels();
		test_random_pixels(400);
		set_all_offsets(9'h100, 9'h0ff, 9'h000, 9'h101, 9'h001, 9'h0ff);
		test_random_pixels(400);
		set_all_offsets(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
			9'($urandom), 9'($urandom));
		test_random_pixels(400);
		set_all_offsets(9'h1f6, 9'h00a, 9'h1e0, 9'h020, 9'h1c0, 9'h040);
		test_random_pixels(400);
		$display("Covered %0d pixels, %0d results, %0d band-corrected, offset extremes included",
			n_items, n_results, n_corrected);
		if (n_errors == 0 && pixel_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* sim.f */
sv/phsc_pkg.sv
sv/phsc_div.sv
sv/phsc_hsv2rgb.sv
sv/pixel_hue_shift_correct.sv
tb/tb_top.sv
